### sv/mcsl_pkg.sv
`default_nettype none

package mcsl_pkg;

	localparam int CHUNK_BYTES = 16;
	localparam int CHUNK_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;

	localparam logic [7:0] SPECIAL_INT_ENABLE = 8'h01;
	localparam logic [7:0] INT_ENABLE_VALUE = 8'h32;

	typedef enum logic [1:0] {
		KIND_MEM   = 2'd0,
		KIND_INT   = 2'd1,
		KIND_BADSP = 2'd2,
		KIND_TRUNC = 2'd3
	} kind_t;

	typedef enum logic [5:0] {
		PH_BANK    = 6'b000001,
		PH_OFFSET  = 6'b000010,
		PH_LENGTH  = 6'b000100,
		PH_DATA    = 6'b001000,
		PH_SPECIAL = 6'b010000,
		PH_DROP    = 6'b100000
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [4:0] mem_bank;
		logic [7:0] mem_address;
		logic [7:0] write_data;
		logic       chunk_start;
		logic       set_final;
	} result_t;

endpackage

`default_nettype wire

### sv/motion_config_set_loader.sv
`default_nettype none

// Configuration-set stream loader. Takes one stream byte per cycle on the byte
// channel while byte_stall is low and parses records of bank, offset, length and
// data bytes (a zero length is followed by one special byte). Each data byte
// yields a registered memory write result (a truncated set result if the set ends
// early); bursts are marked by chunk_start at each record start, every CHUNK_BYTES
// bytes and after an address wrap. Interrupt enable, unknown special and truncated
// set results come out on the same channel. Throughput is one byte per cycle while
// byte_stall is low; a two-entry output buffer keeps the input moving while one
// result waits, and byte_stall rises only when both entries are full.
module motion_config_set_loader
	import mcsl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] cfg_byte,
	input  wire logic       end_of_set,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [1:0]      kind,
	output logic [4:0]      mem_bank,
	output logic [7:0]      mem_address,
	output logic [7:0]      write_data,
	output logic            chunk_start,
	output logic            set_final
);

	phase_t             phase_q, phase_d;
	logic [7:0]         bank_q, bank_d;
	logic [7:0]         addr_q, addr_d;
	logic [7:0]         left_q, left_d;
	logic [CHUNK_W-1:0] fill_q, fill_d;

	result_t res;
	logic    res_valid;
	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;

	logic accept;
	logic out_take;
	logic wrap;
	logic [8:0] fill_inc;

	assign accept   = byte_valid && !byte_stall;
	assign out_take = out_valid_q && !result_stall;
	assign wrap     = (addr_q == 8'hFF);
	assign fill_inc = {{(9-CHUNK_W){1'b0}}, fill_q} + 9'd1;

	always_comb begin
		phase_d   = phase_q;
		bank_d    = bank_q;
		addr_d    = addr_q;
		left_d    = left_q;
		fill_d    = fill_q;
		res       = '0;
		res.kind  = KIND_TRUNC;
		res_valid = 1'b0;
		unique case (phase_q)
			PH_BANK: begin
				bank_d = cfg_byte;
				if (end_of_set) begin
					res.set_final = 1'b1;
					res_valid     = 1'b1;
				end else begin
					phase_d = PH_OFFSET;
				end
			end
			PH_OFFSET: begin
				addr_d = cfg_byte;
				if (end_of_set) begin
					phase_d       = PH_BANK;
					res.set_final = 1'b1;
					res_valid     = 1'b1;
				end else begin
					phase_d = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				left_d = cfg_byte;
				fill_d = '0;
				if (end_of_set) begin
					phase_d       = PH_BANK;
					res.set_final = 1'b1;
					res_valid     = 1'b1;
				end else if (cfg_byte == 8'd0) begin
					phase_d = PH_SPECIAL;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				res_valid = 1'b1;
				if (left_q > 8'd1 && end_of_set) begin
					phase_d       = PH_BANK;
					res.set_final = 1'b1;
				end else begin
					res.kind        = KIND_MEM;
					res.mem_bank    = bank_q[4:0];
					res.mem_address = addr_q;
					res.write_data  = cfg_byte;
					res.chunk_start = (fill_q == '0);
					res.set_final   = end_of_set;
					left_d          = left_q - 8'd1;
					addr_d          = addr_q + 8'd1;
					if (wrap || fill_inc >= 9'(CHUNK_BYTES)) begin
						fill_d = '0;
					end else begin
						fill_d = fill_inc[CHUNK_W-1:0];
					end
					if (wrap && left_q != 8'd1) begin
						bank_d = bank_q + 8'd1;
					end
					if (left_q == 8'd1) begin
						phase_d = PH_BANK;
					end
				end
			end
			PH_SPECIAL: begin
				res_valid     = 1'b1;
				res.set_final = 1'b1;
				phase_d       = end_of_set ? PH_BANK : PH_DROP;
				res.kind      = KIND_BADSP;
				if (cfg_byte == SPECIAL_INT_ENABLE) begin
					phase_d        = PH_BANK;
					res.kind       = KIND_INT;
					res.write_data = INT_ENABLE_VALUE;
					res.set_final  = end_of_set;
				end
			end
			PH_DROP: begin
				if (end_of_set) begin
					phase_d = PH_BANK;
				end
			end
			default: begin
				phase_d = PH_BANK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BANK;
			bank_q  <= '0;
			addr_q  <= '0;
			left_q  <= '0;
			fill_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			bank_q  <= bank_d;
			addr_q  <= addr_d;
			left_q  <= left_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept && res_valid) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (accept && res_valid) begin
			if (!out_valid_q || out_take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign byte_stall   = skid_valid_q;
	assign result_valid = out_valid_q;
	assign kind         = out_q.kind;
	assign mem_bank     = out_q.mem_bank;
	assign mem_address  = out_q.mem_address;
	assign write_data   = out_q.write_data;
	assign chunk_start  = out_q.chunk_start;
	assign set_final    = out_q.set_final;

endmodule

`default_nettype wire

### sv/mcsl_checker.sv
`default_nettype none

module mcsl_checker
	import mcsl_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire logic [1:0] kind,
	input wire logic [4:0] mem_bank,
	input wire logic [7:0] mem_address,
	input wire logic [7:0] write_data,
	input wire logic       chunk_start,
	input wire logic       set_final
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable({kind, mem_bank, mem_address,
			write_data, chunk_start, set_final}))
		else $error("result payload changed while stalled");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_BADSP || kind == KIND_TRUNC) |->
			set_final && write_data == 8'd0 && mem_bank == 5'd0 &&
			mem_address == 8'd0 && !chunk_start)
		else $error("malformed error result");

	a_int_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_INT |->
			write_data == INT_ENABLE_VALUE && mem_bank == 5'd0 &&
			mem_address == 8'd0 && !chunk_start)
		else $error("malformed interrupt enable result");

endmodule

bind motion_config_set_loader mcsl_checker u_mcsl_checker (.*);

`default_nettype wire

### tb/motion_config_set_loader_tb.sv
module motion_config_set_loader_tb;
	import mcsl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	logic [7:0] cfg_byte = 8'h00;
	logic       end_of_set = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [1:0] kind;
	logic [4:0] mem_bank;
	logic [7:0] mem_address;
	logic [7:0] write_data;
	logic       chunk_start;
	logic       set_final;

	motion_config_set_loader uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.cfg_byte(cfg_byte),
		.end_of_set(end_of_set),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.mem_bank(mem_bank),
		.mem_address(mem_address),
		.write_data(write_data),
		.chunk_start(chunk_start),
		.set_final(set_final)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser shadow state
	phase_t     phase_q = PH_BANK;
	logic [7:0] bank_q = 8'h00;
	logic [7:0] addr_q = 8'h00;
	logic [7:0] left_q = 8'h00;
	logic [7:0] fill_q = 8'h00;

	result_t    pending_results[$];
	logic [7:0] stream_q[$];

	int  mismatch_count = 0;
	int  bytes_sent = 0;
	int  results_seen = 0;
	int  hold_left = 0;
	bit  hold_req = 1'b0;
	bit  src_idle = 1'b1;
	bit  sink_idle = 1'b1;

	function automatic void parse_byte(input logic [7:0] b, input logic last);
		result_t r;
		bit      produce;
		r = '0;
		produce = 1'b0;
		case (phase_q)
			PH_BANK: begin
				bank_q = b;
				if (last) begin
					r.kind = KIND_TRUNC;
					r.set_final = 1'b1;
					produce = 1'b1;
				end else begin
					phase_q = PH_OFFSET;
				end
			end
			PH_OFFSET: begin
				addr_q = b;
				if (last) begin
					r.kind = KIND_TRUNC;
					r.set_final = 1'b1;
					produce = 1'b1;
					phase_q = PH_BANK;
				end else begin
					phase_q = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				left_q = b;
				fill_q = 8'h00;
				if (last) begin
					r.kind = KIND_TRUNC;
					r.set_final = 1'b1;
					produce = 1'b1;
					phase_q = PH_BANK;
				end else if (b == 8'h00) begin
					phase_q = PH_SPECIAL;
				end else begin
					phase_q = PH_DATA;
				end
			end
			PH_DATA: begin
				produce = 1'b1;
				if (left_q > 8'd1 && last) begin
					r.kind = KIND_TRUNC;
					r.set_final = 1'b1;
					phase_q = PH_BANK;
				end else begin
					r.kind = KIND_MEM;
					r.mem_bank = bank_q[4:0];
					r.mem_address = addr_q;
					r.write_data = b;
					r.chunk_start = (fill_q == 8'h00);
					r.set_final = last;
					if (int'(fill_q) + 1 >= CHUNK_BYTES)
						fill_q = 8'h00;
					else
						fill_q = fill_q + 8'd1;
					left_q = left_q - 8'd1;
					addr_q = addr_q + 8'd1;
					if (addr_q == 8'h00) begin
						fill_q = 8'h00;
						if (left_q != 8'h00)
							bank_q = bank_q + 8'd1;
					end
					if (left_q == 8'h00)
						phase_q = PH_BANK;
				end
			end
			PH_SPECIAL: begin
				produce = 1'b1;
				if (b == SPECIAL_INT_ENABLE) begin
					r.kind = KIND_INT;
					r.write_data = INT_ENABLE_VALUE;
					r.set_final = last;
					phase_q = PH_BANK;
				end else begin
					r.kind = KIND_BADSP;
					r.set_final = 1'b1;
					phase_q = last ? PH_BANK : PH_DROP;
				end
			end
			default: begin
				if (last)
					phase_q = PH_BANK;
			end
		endcase
		if (produce)
			pending_results.push_back(r);
	endfunction

	// one transaction on the byte channel; returns at the accepting edge
	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while (src_idle && $urandom_range(99) < 24) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		cfg_byte <= b;
		end_of_set <= last;
		do @(posedge clk); while (byte_stall);
		parse_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_seq(input logic [7:0] seq[$]);
		for (int i = 0; i < seq.size(); i++)
			send_byte(seq[i], i == seq.size() - 1);
	endtask

	function automatic void add_record();
		int r;
		int len;
		r = $urandom_range(99);
		stream_q.push_back(8'($urandom_range(255)));
		if ($urandom_range(2) == 0)
			stream_q.push_back(8'(8'hF0 + $urandom_range(15)));
		else
			stream_q.push_back(8'($urandom_range(255)));
		if (r < 10) begin
			stream_q.push_back(8'h00);
			if ($urandom_range(4) == 0)
				stream_q.push_back(8'($urandom_range(255)));
			else
				stream_q.push_back(SPECIAL_INT_ENABLE);
		end else begin
			len = (r < 13) ? $urandom_range(40, 255) : $urandom_range(1, 24);
			stream_q.push_back(8'(len));
			repeat (len) stream_q.push_back(8'($urandom_range(255)));
		end
	endfunction

	// well-formed sets of records, some cut short at a random byte
	task automatic run_sets(input int n_bytes, input int cut_pct);
		int stop_at;
		int cut_at;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			stream_q.delete();
			repeat ($urandom_range(1, 4)) add_record();
			if ($urandom_range(99) < cut_pct)
				cut_at = $urandom_range(stream_q.size() - 1);
			else
				cut_at = stream_q.size() - 1;
			for (int i = 0; i <= cut_at; i++)
				send_byte(stream_q[i], i == cut_at);
		end
	endtask

	task automatic test_records_and_specials();
		// wrap inside a record, interrupt enable, wrap at record end, bad special then drop
		send_seq('{8'hFF, 8'hFE, 8'h03, 8'h00, 8'hFF, 8'hA5,
			8'h00, 8'h00, 8'h00, 8'h01,
			8'h05, 8'hFF, 8'h01, 8'h7E,
			8'h00, 8'h00, 8'h00, 8'hFE,
			8'h55, 8'hAA});
	endtask

	task automatic test_truncation();
		send_seq('{8'h07});
		send_seq('{8'h00, 8'h00});
		send_seq('{8'h01, 8'h02, 8'h05});
		send_seq('{8'h01, 8'h02, 8'h00});
		send_seq('{8'h00, 8'h00, 8'h02, 8'h11});
		// bad special on the final byte
		send_seq('{8'h00, 8'h00, 8'h00, 8'h80});
	endtask

	task automatic test_steady_stream();
		src_idle = 1'b0;
		sink_idle = 1'b0;
		run_sets(150, 10);
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		src_idle = 1'b0;
		run_sets(60, 0);
		src_idle = 1'b1;
	endtask

	task automatic test_random_sets();
		run_sets(400, 12);
	endtask

	task automatic test_noise();
		repeat (80) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
		send_byte(8'($urandom_range(255)), 1'b1);
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (sink_idle) begin
			result_stall <= ($urandom_range(99) < 24);
		end else begin
			result_stall <= 1'b0;
		end
	end

	function automatic void check_field(input string name, input int want, input logic [7:0] got);
		if (got !== 8'(want)) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected transaction: kind %0d bank %0d address %0d data %0d",
					kind, mem_bank, mem_address, write_data);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", int'(want.kind), {6'b0, kind});
				check_field("mem_bank", int'(want.mem_bank), {3'b0, mem_bank});
				check_field("mem_address", int'(want.mem_address), mem_address);
				check_field("write_data", int'(want.write_data), write_data);
				check_field("chunk_start", int'(want.chunk_start), {7'b0, chunk_start});
				check_field("set_final", int'(want.set_final), {7'b0, set_final});
			end
		end
	end

	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int drain;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_records_and_specials();
		test_truncation();
		test_steady_stream();
		test_backpressure();
		test_random_sets();
		test_noise();

		@(negedge clk);
		byte_valid <= 1'b0;
		drain = 0;
		while (pending_results.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected transactions never arrived", pending_results.size());
			mismatch_count++;
		end

		$display("sent %0d stream bytes, checked %0d results", bytes_sent, results_seen);
		$display("records with wraps and bursts, specials, truncated and dropped sets, full stall");
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
